// ===== rtl/core/opa_pkg.sv =====
// shared types, constants and helper functions of the operator probability adapter
`timescale 1ns / 1ps

package opa_pkg;

    localparam int MaxOps  = 8;
    localparam int OpW     = $clog2(MaxOps);
    localparam int NumW    = $clog2(MaxOps + 1);
    localparam int ProbW   = 17;
    localparam int SumW    = 48;
    localparam int CntW    = 16;
    localparam int FitW    = 32;
    localparam int GenW    = 16;
    localparam int CfgW    = 17;
    localparam int CfgIdxW = 2;
    localparam int GainW   = ProbW + OpW;
    localparam int DvsW    = GenW + NumW;
    localparam int DivQW   = ProbW + 1;
    localparam int HalfW   = SumW / 2;
    localparam int MulW    = HalfW + 1 + CntW + 1;
    localparam int FullW   = MulW + HalfW;
    localparam int InW     = OpW + FitW;
    localparam int OutW    = OpW + ProbW + OpW;

    localparam int OneQ16Int = 65536;
    localparam logic [ProbW-1:0] OneQ16   = ProbW'(OneQ16Int);
    localparam logic [CntW-1:0]  CountMax = '1;
    localparam logic [DivQW-1:0] PenNumer = DivQW'(2 * OneQ16Int);
    localparam logic [SumW-1:0]  SumMax   = {1'b0, {(SumW - 1){1'b1}}};
    localparam logic [SumW-1:0]  SumMin   = {1'b1, {(SumW - 1){1'b0}}};

    localparam logic [NumW-1:0]  ResetOps  = NumW'(5);
    localparam logic [GenW-1:0]  ResetGens = GenW'(100);

    typedef enum logic [CfgIdxW-1:0] {
        CFG_NUM_OPERATORS   = 2'd0,
        CFG_NUM_GENERATIONS = 2'd1,
        CFG_PROB_FLOOR      = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic accum;
        logic search_init;
        logic idx_clr;
        logic idx_inc;
        logic take;
        logic mul_lo;
        logic mul_hi;
        logic mul_sum;
        logic compare;
        logic div_start;
        logic pen_init;
        logic pen_step;
        logic win_update;
        logic clear_acc;
        logic emit_load;
    } opa_cmd_t;

    typedef struct packed {
        logic cur_used;
        logic idx_last;
        logic found;
        logic div_done;
        logic out_free;
    } opa_stat_t;

    function automatic logic [NumW-1:0] clamp_ops(input logic [NumW-1:0] v);
        logic [NumW-1:0] r;
        r = v;
        if (v < NumW'(2)) begin
            r = NumW'(2);
        end else if (v > NumW'(MaxOps)) begin
            r = NumW'(MaxOps);
        end
        return r;
    endfunction

    function automatic logic [ProbW-1:0] equal_share(input logic [NumW-1:0] n);
        logic [ProbW-1:0] r;
        case (n)
            NumW'(2): r = ProbW'(OneQ16Int / 2);
            NumW'(3): r = ProbW'(OneQ16Int / 3);
            NumW'(4): r = ProbW'(OneQ16Int / 4);
            NumW'(5): r = ProbW'(OneQ16Int / 5);
            NumW'(6): r = ProbW'(OneQ16Int / 6);
            NumW'(7): r = ProbW'(OneQ16Int / 7);
            NumW'(8): r = ProbW'(OneQ16Int / 8);
            default:  r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/opa_div.sv =====
// restoring divider computing the per-generation penalty from the run length and the operator count
`timescale 1ns / 1ps

module opa_div
    import opa_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DvsW-1:0]  divisor,
    output logic             done,
    output logic [ProbW-1:0] quotient
);

    localparam int StepW = $clog2(DivQW);

    logic              busy_reg;
    logic              done_reg;
    logic [StepW-1:0]  step_reg;
    logic [DivQW-1:0]  dq_reg;
    logic [DvsW-1:0]   rem_reg;
    logic [DvsW-1:0]   dvs_reg;

    logic [DvsW:0]     trial;
    logic              ge;
    logic [DvsW:0]     diff;

    assign trial = {rem_reg, dq_reg[DivQW-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == StepW'(DivQW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg + StepW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dq_reg  <= PenNumer;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DvsW-1:0] : trial[DvsW-1:0];
            dq_reg  <= {dq_reg[DivQW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg[ProbW-1:0];

endmodule

// ===== rtl/core/opa_dpath.sv =====
// datapath: config registers, per-operator accumulators, mean compare, penalty update, output
`timescale 1ns / 1ps

module opa_dpath
    import opa_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_wdata,
    input  logic [InW-1:0]     in_data,
    input  opa_cmd_t           cmd,
    output opa_stat_t          stat,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OutW:0]      m_tdata,
    output logic               m_tlast
);

    logic [NumW-1:0]         num_ops_reg;
    logic [GenW-1:0]         num_gens_reg;
    logic [ProbW-1:0]        floor_reg;

    logic [ProbW-1:0]        prob_reg [MaxOps];
    logic [SumW-1:0]         sum_reg  [MaxOps];
    logic [CntW-1:0]         cnt_reg  [MaxOps];

    logic [OpW-1:0]          idx_reg;
    logic                    found_reg;
    logic [OpW-1:0]          win_idx_reg;
    logic [SumW-1:0]         win_sum_reg;
    logic [CntW-1:0]         win_cnt_reg;
    logic signed [MulW-1:0]  prod_lo_a_reg, prod_lo_b_reg;
    logic signed [MulW-1:0]  prod_hi_a_reg, prod_hi_b_reg;
    logic signed [FullW-1:0] full_a_reg, full_b_reg;
    logic [GainW-1:0]        gained_reg;

    logic                    m_valid_reg;
    logic [OpW-1:0]          out_op_reg;
    logic [ProbW-1:0]        out_prob_reg;
    logic [OpW-1:0]          out_win_reg;
    logic                    out_last_reg;

    logic [OpW-1:0]          op_in;
    logic [FitW-1:0]         fit_in;
    logic [NumW-1:0]         n_act;
    logic [NumW-1:0]         cfg_n;
    logic [OpW-1:0]          acc_addr;
    logic [OpW-1:0]          prob_addr;
    logic [SumW-1:0]         sum_rd;
    logic [CntW-1:0]         cnt_rd;
    logic [ProbW-1:0]        prob_rd;
    logic [SumW:0]           sum_ext;
    logic [SumW-1:0]         sum_sat;
    logic                    acc_ok;
    logic [HalfW:0]          a_op, b_op;
    logic signed [MulW-1:0]  mul_a, mul_b;
    logic signed [FullW-1:0] full_a, full_b;
    logic                    greater;
    logic [GenW-1:0]         gens_eff;
    logic [DvsW-1:0]         divisor;
    logic                    div_done;
    logic [ProbW-1:0]        penalty;
    logic [ProbW-1:0]        floor_q;
    logic [ProbW-1:0]        above;
    logic [GainW:0]          win_sum;
    logic                    out_free;

    assign op_in  = in_data[OpW-1:0];
    assign fit_in = in_data[InW-1:OpW];
    assign n_act  = clamp_ops(num_ops_reg);
    assign cfg_n  = clamp_ops(cfg_wdata[NumW-1:0]);

    // one read port per store, address picked by the current step
    assign acc_addr  = cmd.accum ? op_in : idx_reg;
    assign prob_addr = cmd.win_update ? win_idx_reg : idx_reg;
    assign sum_rd    = sum_reg[acc_addr];
    assign cnt_rd    = cnt_reg[acc_addr];
    assign prob_rd   = prob_reg[prob_addr];

    assign sum_ext = {sum_rd[SumW-1], sum_rd} + {{(SumW + 1 - FitW){fit_in[FitW-1]}}, fit_in};
    assign sum_sat = (sum_ext[SumW] != sum_ext[SumW-1]) ?
                     (sum_ext[SumW] ? SumMin : SumMax) : sum_ext[SumW-1:0];
    assign acc_ok  = ({1'b0, op_in} < n_act) && (cnt_rd != CountMax);

    // cross products of the means, split in two halves of the sum
    assign a_op  = cmd.mul_hi ? {sum_rd[SumW-1], sum_rd[SumW-1:HalfW]}
                              : {1'b0, sum_rd[HalfW-1:0]};
    assign b_op  = cmd.mul_hi ? {win_sum_reg[SumW-1], win_sum_reg[SumW-1:HalfW]}
                              : {1'b0, win_sum_reg[HalfW-1:0]};
    assign mul_a = $signed(a_op) * $signed({1'b0, win_cnt_reg});
    assign mul_b = $signed(b_op) * $signed({1'b0, cnt_rd});

    assign full_a  = $signed({prod_hi_a_reg, {HalfW{1'b0}}})
                   + $signed({{HalfW{prod_lo_a_reg[MulW-1]}}, prod_lo_a_reg});
    assign full_b  = $signed({prod_hi_b_reg, {HalfW{1'b0}}})
                   + $signed({{HalfW{prod_lo_b_reg[MulW-1]}}, prod_lo_b_reg});
    assign greater = full_a_reg > full_b_reg;

    assign gens_eff = (num_gens_reg == '0) ? GenW'(1) : num_gens_reg;
    assign divisor  = gens_eff * n_act;
    assign floor_q  = (floor_reg > OneQ16) ? OneQ16 : floor_reg;
    assign above    = prob_rd - floor_q;
    assign win_sum  = {{(GainW + 1 - ProbW){1'b0}}, prob_rd} + {1'b0, gained_reg};

    opa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (penalty)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_ops_reg  <= ResetOps;
            num_gens_reg <= ResetGens;
            floor_reg    <= '0;
            for (int i = 0; i < MaxOps; i++) begin
                prob_reg[i] <= (i < int'(ResetOps)) ? equal_share(ResetOps) : '0;
                sum_reg[i]  <= '0;
                cnt_reg[i]  <= '0;
            end
            idx_reg     <= '0;
            found_reg   <= 1'b0;
            win_idx_reg <= '0;
            gained_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_NUM_OPERATORS) begin
                    num_ops_reg <= cfg_wdata[NumW-1:0];
                    found_reg   <= 1'b0;
                    for (int i = 0; i < MaxOps; i++) begin
                        prob_reg[i] <= (i < int'(cfg_n)) ? equal_share(cfg_n) : '0;
                        sum_reg[i]  <= '0;
                        cnt_reg[i]  <= '0;
                    end
                end else if (cfg_index == CFG_NUM_GENERATIONS) begin
                    num_gens_reg <= cfg_wdata[GenW-1:0];
                end else if (cfg_index == CFG_PROB_FLOOR) begin
                    floor_reg <= cfg_wdata[ProbW-1:0];
                end
            end

            if (cmd.accum && acc_ok) begin
                sum_reg[op_in] <= sum_sat;
                cnt_reg[op_in] <= cnt_rd + CntW'(1);
            end
            if (cmd.clear_acc) begin
                for (int i = 0; i < MaxOps; i++) begin
                    sum_reg[i] <= '0;
                    cnt_reg[i] <= '0;
                end
            end

            if (cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + OpW'(1);
            end

            if (cmd.search_init) begin
                found_reg   <= 1'b0;
                win_idx_reg <= '0;
            end
            if (cmd.take || (cmd.compare && greater)) begin
                found_reg   <= 1'b1;
                win_idx_reg <= idx_reg;
            end

            if (cmd.pen_init) begin
                gained_reg <= '0;
            end
            if (cmd.pen_step && (idx_reg != win_idx_reg) && (prob_rd > floor_q)) begin
                if (above < penalty) begin
                    prob_reg[idx_reg] <= floor_q;
                    gained_reg        <= gained_reg + GainW'(above);
                end else begin
                    prob_reg[idx_reg] <= prob_rd - penalty;
                    gained_reg        <= gained_reg + GainW'(penalty);
                end
            end
            if (cmd.win_update) begin
                prob_reg[win_idx_reg] <= (win_sum > (GainW + 1)'(OneQ16)) ?
                                         OneQ16 : win_sum[ProbW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take || (cmd.compare && greater)) begin
            win_sum_reg <= sum_rd;
            win_cnt_reg <= cnt_rd;
        end
        if (cmd.mul_lo) begin
            prod_lo_a_reg <= mul_a;
            prod_lo_b_reg <= mul_b;
        end
        if (cmd.mul_hi) begin
            prod_hi_a_reg <= mul_a;
            prod_hi_b_reg <= mul_b;
        end
        if (cmd.mul_sum) begin
            full_a_reg <= full_a;
            full_b_reg <= full_b;
        end
    end

    // output register
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            out_op_reg   <= idx_reg;
            out_prob_reg <= prob_rd;
            out_win_reg  <= win_idx_reg;
            out_last_reg <= stat.idx_last;
        end
    end

    assign stat.cur_used = cnt_rd != '0;
    assign stat.idx_last = idx_reg == OpW'(n_act - NumW'(1));
    assign stat.found    = found_reg;
    assign stat.div_done = div_done;
    assign stat.out_free = out_free;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_win_reg, out_prob_reg, out_op_reg};
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_found_has_uses: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> win_cnt_reg != '0)
        else $error("winner recorded with no uses");

    a_winner_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> {1'b0, win_idx_reg} < n_act)
        else $error("winner index beyond active operators");

    a_prob_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> out_prob_reg <= OneQ16)
        else $error("probability above one");
`endif

endmodule

// ===== rtl/core/opa_ctrl.sv =====
// controller: sequences accumulate, winner search, penalty division, update and result output
`timescale 1ns / 1ps

module opa_ctrl
    import opa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  logic      s_tlast,
    output logic      s_tready,
    input  opa_stat_t stat,
    output opa_cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_SCAN = 10'b0000000010,
        S_MLO  = 10'b0000000100,
        S_MHI  = 10'b0000001000,
        S_MSUM = 10'b0000010000,
        S_MCMP = 10'b0000100000,
        S_DIV  = 10'b0001000000,
        S_PEN  = 10'b0010000000,
        S_WIN  = 10'b0100000000,
        S_EMIT = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accum = 1'b1;
                    if (s_tlast) begin
                        cmd.search_init = 1'b1;
                        cmd.idx_clr     = 1'b1;
                        state_next      = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (stat.cur_used && stat.found) begin
                    state_next = S_MLO;
                end else begin
                    cmd.take = stat.cur_used;
                    if (stat.idx_last) begin
                        if (stat.cur_used || stat.found) begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIV;
                        end else begin
                            cmd.clear_acc = 1'b1;
                            cmd.idx_clr   = 1'b1;
                            state_next    = S_EMIT;
                        end
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_MLO: begin
                cmd.mul_lo = 1'b1;
                state_next = S_MHI;
            end
            S_MHI: begin
                cmd.mul_hi = 1'b1;
                state_next = S_MSUM;
            end
            S_MSUM: begin
                cmd.mul_sum = 1'b1;
                state_next  = S_MCMP;
            end
            S_MCMP: begin
                cmd.compare = 1'b1;
                if (stat.idx_last) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_DIV: begin
                if (stat.div_done) begin
                    cmd.pen_init = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    state_next   = S_PEN;
                end
            end
            S_PEN: begin
                cmd.pen_step = 1'b1;
                if (stat.idx_last) begin
                    state_next = S_WIN;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_WIN: begin
                cmd.win_update = 1'b1;
                cmd.clear_acc  = 1'b1;
                cmd.idx_clr    = 1'b1;
                state_next     = S_EMIT;
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit_load = 1'b1;
                    if (stat.idx_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/operator_probability_adapter.sv =====
// Operator probability adapter: one item per individual carries the operator it used and
// its fitness. An item that is not marked last is accumulated into that operator's fitness
// sum and use count, so such items stream at one per clock. The item
// marked last starts the generation update, during which no item is taken: the winner
// search visits each of the n active operators, and for every used one after the first
// runs two half-width multiply passes, a sum and a compare of the cross products
// sum_i*count_w against sum_w*count_i; if any operator was used, the penalty
// 2/(generations*n) then comes from a restoring divider in 18 shift steps, is applied to
// each active operator but the winner in turn, and the winner is credited with what the
// others gave; if none was used, the probabilities stay. Then n results leave through the
// output register, one per cycle while the sink takes them. Writing num_operators resets
// the active probabilities to the equal share, zeroes the rest and clears the accumulators.
`timescale 1ns / 1ps

module operator_probability_adapter
    import opa_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [39:0]        s_tdata,   // operator_index, fitness
    input  logic               s_tlast,   // last_item
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,   // result_operator, probability, winner_index
    output logic               m_tlast    // last_result
);

    opa_cmd_t  cmd;
    opa_stat_t stat;

    opa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    opa_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata[InW-1:0]),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== bench/operator_probability_adapter_tb.sv =====
// testbench of the operator probability adapter: directed table and random generations
`timescale 1ns / 1ps

module operator_probability_adapter_tb;
    import opa_pkg::*;

    typedef struct packed {
        logic [OpW-1:0]   op;
        logic [ProbW-1:0] prob;
        logic [OpW-1:0]   win;
        logic             last;
    } prob_report_t;

    typedef struct packed {
        logic             is_cfg;
        cfg_idx_t         idx;
        logic [CfgW-1:0]  val;
        logic [OpW-1:0]   op;
        logic [FitW-1:0]  fit;
        logic             last;
        logic             pin;
        logic [OpW-1:0]   win;
    } stim_row_t;

    localparam int NumDir = 30;
    localparam longint FitSumMax = 64'sd140737488355327;
    localparam longint FitSumMin = -64'sd140737488355328;

    // register writes and individuals in order; winner typed in on each last individual
    localparam stim_row_t DirRows [NumDir] = '{
        '{1'b0, CFG_NUM_OPERATORS,   17'd0,      3'd2, 32'h0001_0000, 1'b1, 1'b1, 3'd2},
        '{1'b0, CFG_NUM_OPERATORS,   17'd0,      3'd5, 32'h7fff_ffff, 1'b1, 1'b1, 3'd0},
        '{1'b0, CFG_NUM_OPERATORS,   17'd0,      3'd0, 32'h8000_0000, 1'b0, 1'b0, 3'd0},
        '{1'b0, CFG_NUM_OPERATORS,   17'd0,      3'd1, 32'h8000_0000, 1'b0, 1'b0, 3'd0},
        '{1'b0, CFG_NUM_OPERATORS,   17'd0,      3'd3, 32'h7fff_ffff, 1'b0, 1'b0, 3'd0},
        '{1'b0, CFG_NUM_OPERATORS,   17'd0,      3'd4, 32'h7fff_ffff, 1'b1, 1'b1, 3'd3},
        '{1'b0, CFG_NUM_OPERATORS,   17'd0,      3'd1, 32'hffff_fffb, 1'b0, 1'b0, 3'd0},
        '{1'b0, CFG_NUM_OPERATORS,   17'd0,      3'd2, 32'hffff_fffd, 1'b1, 1'b1, 3'd2},
        '{1'b1, CFG_NUM_OPERATORS,   17'd8,      3'd0, 32'h0,         1'b0, 1'b0, 3'd0},
        '{1'b1, CFG_NUM_GENERATIONS, 17'd65535,  3'd0, 32'h0,         1'b0, 1'b0, 3'd0},
        '{1'b0, CFG_NUM_OPERATORS,   17'd0,      3'd7, 32'h0000_0005, 1'b0, 1'b0, 3'd0},
        '{1'b0, CFG_NUM_OPERATORS,   17'd0,      3'd6, 32'h0000_0005, 1'b1, 1'b1, 3'd6},
        '{1'b1, CFG_NUM_GENERATIONS, 17'd0,      3'd0, 32'h0,         1'b0, 1'b0, 3'd0},
        '{1'b1, CFG_PROB_FLOOR,      17'd8000,   3'd0, 32'h0,         1'b0, 1'b0, 3'd0},
        '{1'b0, CFG_NUM_OPERATORS,   17'd0,      3'd0, 32'h0000_0001, 1'b1, 1'b1, 3'd0},
        '{1'b1, CFG_PROB_FLOOR,      17'h1ffff,  3'd0, 32'h0,         1'b0, 1'b0, 3'd0},
        '{1'b0, CFG_NUM_OPERATORS,   17'd0,      3'd1, 32'hffff_ffff, 1'b1, 1'b1, 3'd1},
        '{1'b1, CFG_NUM_OPERATORS,   17'd0,      3'd0, 32'h0,         1'b0, 1'b0, 3'd0},
        '{1'b1, CFG_PROB_FLOOR,      17'd0,      3'd0, 32'h0,         1'b0, 1'b0, 3'd0},
        '{1'b1, CFG_NUM_GENERATIONS, 17'd1,      3'd0, 32'h0,         1'b0, 1'b0, 3'd0},
        '{1'b0, CFG_NUM_OPERATORS,   17'd0,      3'd1, 32'h1234_5678, 1'b0, 1'b0, 3'd0},
        '{1'b0, CFG_NUM_OPERATORS,   17'd0,      3'd0, 32'h0000_0001, 1'b0, 1'b0, 3'd0},
        '{1'b0, CFG_NUM_OPERATORS,   17'd0,      3'd6, 32'h0000_0000, 1'b0, 1'b0, 3'd0},
        '{1'b0, CFG_NUM_OPERATORS,   17'd0,      3'd1, 32'h0000_0000, 1'b1, 1'b1, 3'd1},
        '{1'b1, CFG_NUM_OPERATORS,   17'd15,     3'd0, 32'h0,         1'b0, 1'b0, 3'd0},
        '{1'b0, CFG_NUM_OPERATORS,   17'd0,      3'd3, 32'h0000_000a, 1'b0, 1'b0, 3'd0},
        '{1'b0, CFG_NUM_OPERATORS,   17'd0,      3'd3, 32'h0000_0014, 1'b0, 1'b0, 3'd0},
        '{1'b0, CFG_NUM_OPERATORS,   17'd0,      3'd5, 32'h0000_000e, 1'b0, 1'b0, 3'd0},
        '{1'b0, CFG_NUM_OPERATORS,   17'd0,      3'd5, 32'h0000_0010, 1'b0, 1'b0, 3'd0},
        '{1'b0, CFG_NUM_OPERATORS,   17'd0,      3'd5, 32'h0000_000f, 1'b1, 1'b1, 3'd3}
    };

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [CfgW-1:0]    cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [39:0]        s_tdata   = '0;   // operator_index, fitness
    logic               s_tlast   = 1'b0; // last_item
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [23:0]        m_tdata;          // result_operator, probability, winner_index
    logic               m_tlast;          // last_result

    logic gaps_on  = 1'b1;
    logic stall_on = 1'b1;
    int   mismatch_count = 0;

    // predicted block state
    int unsigned  ops_reg;
    int unsigned  gens_reg;
    int unsigned  floor_reg;
    int unsigned  share_q [MaxOps];
    longint       fit_sum_q [MaxOps];
    int           uses_q [MaxOps];
    prob_report_t pending_reports [$];
    prob_report_t got_report;

    operator_probability_adapter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #6000000;
        $display("Verification failed");
        $finish;
    end

    function automatic int unsigned ops_active();
        int unsigned n;
        n = ops_reg;
        if (n < 2) begin
            n = 2;
        end else if (n > MaxOps) begin
            n = MaxOps;
        end
        return n;
    endfunction

    task automatic reset_shares();
        int unsigned n;
        n = ops_active();
        for (int i = 0; i < MaxOps; i++) begin
            share_q[i]   = (i < n) ? OneQ16Int / n : 0;
            fit_sum_q[i] = 0;
            uses_q[i]    = 0;
        end
    endtask

    // accumulate one individual; on the last one, settle the generation
    task automatic model_individual(input logic [OpW-1:0] op, input logic [FitW-1:0] fit,
                                    input logic last, input logic pin,
                                    input logic [OpW-1:0] pin_win);
        int unsigned  n, gens, penalty, floor_q, gained, p, win;
        longint       s;
        logic         found;
        prob_report_t rep;
        n = ops_active();
        if (op < n && uses_q[op] < int'(CountMax)) begin
            s = fit_sum_q[op] + longint'($signed(fit));
            if (s > FitSumMax) begin
                s = FitSumMax;
            end else if (s < FitSumMin) begin
                s = FitSumMin;
            end
            fit_sum_q[op] = s;
            uses_q[op]++;
        end
        if (last) begin
            found = 1'b0;
            win   = 0;
            for (int i = 0; i < n; i++) begin
                if (uses_q[i] != 0) begin
                    if (!found || fit_sum_q[i] * longint'(uses_q[win])
                                  > fit_sum_q[win] * longint'(uses_q[i])) begin
                        win   = i;
                        found = 1'b1;
                    end
                end
            end
            if (found) begin
                gens    = (gens_reg == 0) ? 1 : gens_reg;
                penalty = (2 * OneQ16Int) / (gens * n);
                floor_q = (floor_reg > OneQ16Int) ? OneQ16Int : floor_reg;
                gained  = 0;
                for (int i = 0; i < n; i++) begin
                    p = share_q[i];
                    if (i != win && p > floor_q) begin
                        if (p - floor_q < penalty) begin
                            gained += p - floor_q;
                            share_q[i] = floor_q;
                        end else begin
                            share_q[i] = p - penalty;
                            gained += penalty;
                        end
                    end
                end
                p = share_q[win] + gained;
                share_q[win] = (p > OneQ16Int) ? OneQ16Int : p;
            end
            for (int i = 0; i < n; i++) begin
                rep.op   = OpW'(i);
                rep.prob = ProbW'(share_q[i]);
                rep.win  = pin ? pin_win : OpW'(win);
                rep.last = (i == n - 1);
                pending_reports.push_back(rep);
            end
            for (int i = 0; i < MaxOps; i++) begin
                fit_sum_q[i] = 0;
                uses_q[i]    = 0;
            end
        end
    endtask

    task automatic cfg_write(input cfg_idx_t idx, input int unsigned val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CfgW'(val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_NUM_OPERATORS: begin
                ops_reg = val & 32'hf;
                reset_shares();
            end
            CFG_NUM_GENERATIONS: gens_reg = val & 32'hffff;
            CFG_PROB_FLOOR: floor_reg = val & 32'h1ffff;
            default: ;
        endcase
    endtask

    task automatic send_individual(input logic [OpW-1:0] op, input logic [FitW-1:0] fit,
                                   input logic last, input logic pin,
                                   input logic [OpW-1:0] pin_win);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, fit, op};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        model_individual(op, fit, last, pin, pin_win);
    endtask

    // block idle: all reports in and the update pass finished
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input longint unsigned exp_v,
                               input longint unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // sink side backpressure
    initial begin : sink
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
            end else if (stall_on && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 7);
            end
            m_tready <= (hold == 0);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual %h last %b",
                         $time, m_tdata, m_tlast);
                mismatch_count++;
            end else begin
                got_report = pending_reports.pop_front();
                check_field("result_operator", got_report.op, m_tdata[2:0]);
                check_field("probability", got_report.prob, m_tdata[19:3]);
                check_field("winner_index", got_report.win, m_tdata[22:20]);
                check_field("last_result", got_report.last, m_tlast);
            end
        end
    end

    initial begin : stimulus
        int unsigned      len, n, rand_items;
        logic [OpW-1:0]   op;
        logic [FitW-1:0]  fit;
        ops_reg   = 5;
        gens_reg  = 100;
        floor_reg = 0;
        reset_shares();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < NumDir; r++) begin
            if (DirRows[r].is_cfg) begin
                wait_drained();
                cfg_write(DirRows[r].idx, DirRows[r].val);
            end else begin
                send_individual(DirRows[r].op, DirRows[r].fit, DirRows[r].last,
                                DirRows[r].pin, DirRows[r].win);
            end
        end

        rand_items = 0;
        while (rand_items < 220) begin
            if (rand_items < 180) begin
                wait_drained();
                if ($urandom_range(0, 2) == 0) begin
                    cfg_write(CFG_NUM_OPERATORS, $urandom_range(0, 15));
                end
                if ($urandom_range(0, 2) == 0) begin
                    case ($urandom_range(0, 4))
                        0: cfg_write(CFG_NUM_GENERATIONS, 0);
                        1: cfg_write(CFG_NUM_GENERATIONS, 1);
                        2: cfg_write(CFG_NUM_GENERATIONS, 65535);
                        3: cfg_write(CFG_NUM_GENERATIONS, $urandom_range(1, 300));
                        default: cfg_write(CFG_NUM_GENERATIONS, $urandom_range(0, 65535));
                    endcase
                end
                if ($urandom_range(0, 2) == 0) begin
                    case ($urandom_range(0, 4))
                        0: cfg_write(CFG_PROB_FLOOR, 0);
                        1: cfg_write(CFG_PROB_FLOOR, OneQ16Int);
                        2: cfg_write(CFG_PROB_FLOOR, 17'h1ffff);
                        3: cfg_write(CFG_PROB_FLOOR, $urandom_range(0, 16384));
                        default: cfg_write(CFG_PROB_FLOOR, $urandom_range(0, 131071));
                    endcase
                end
            end
            repeat ($urandom_range(1, 4)) begin
                gaps_on  = (rand_items < 180) && ($urandom_range(0, 3) != 0);
                stall_on = (rand_items < 180) && ($urandom_range(0, 3) != 0);
                len = $urandom_range(1, 12);
                for (int j = 0; j < len; j++) begin
                    n  = ops_active();
                    op = ($urandom_range(0, 9) == 0) ? OpW'($urandom_range(0, 7))
                                                     : OpW'($urandom_range(0, n - 1));
                    case ($urandom_range(0, 5))
                        0: fit = 32'h7fff_ffff;
                        1: fit = 32'h8000_0000;
                        2: fit = 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
                        default: fit = $urandom;
                    endcase
                    send_individual(op, fit, (j == len - 1), 1'b0, 3'd0);
                    rand_items++;
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
